// ----- rtl/core/bl2x_pkg.sv -----
package bl2x_pkg;

  // fixed field widths
  localparam int XY_W       = 11;
  localparam int ROW_W      = 10;
  localparam int ROW_LIMIT  = 1024;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 2;

  localparam int RESET_LOW_WIDTH  = 640;
  localparam int RESET_LOW_HEIGHT = 360;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_HEIGHT = 2'd1;

  // result order within one cell
  localparam logic [1:0] BEAT_RIGHT  = 2'd0;
  localparam logic [1:0] BEAT_BELOW  = 2'd1;
  localparam logic [1:0] BEAT_CENTER = 2'd2;

  // full-res top-left corner of a cell
  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
  } cell_pos_t;

  typedef struct packed {
    logic emit;      // item closes a cell
    logic last_col;  // item sits in the last column of the row
  } item_ctl_t;

endpackage

// ----- rtl/core/bl2x_ram.sv -----
module bl2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bl2x_interp.sv -----
module bl2x_interp #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [3*CHANNEL_BITS-1:0]   load_px,
  input  logic [3*CHANNEL_BITS-1:0]   load_bl,
  input  bl2x_pkg::cell_pos_t         load_pos,
  input  bl2x_pkg::item_ctl_t         load_ctl,
  output logic                        ready,
  input  logic [3*CHANNEL_BITS-1:0]   rd_data,
  input  logic                        out_ready,
  output logic                        cell_valid,
  output bl2x_pkg::cell_pos_t         cell_pos,
  output logic [3*CHANNEL_BITS-1:0]   right_color,
  output logic [3*CHANNEL_BITS-1:0]   below_color,
  output logic [3*CHANNEL_BITS-1:0]   center_color
);
  import bl2x_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int PIX_W = 3 * CB;

  function automatic logic [PIX_W-1:0] mean2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    logic [CB:0]      s;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = {1'b0, a[k*CB +: CB]} + {1'b0, b[k*CB +: CB]};
      r[k*CB +: CB] = s[CB:1];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] mean4(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c,
                                             input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] r;
    logic [CB+1:0]    s;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = {2'b00, a[k*CB +: CB]} + {2'b00, b[k*CB +: CB]}
        + {2'b00, c[k*CB +: CB]} + {2'b00, d[k*CB +: CB]};
      r[k*CB +: CB] = s[CB+1:2];
    end
    return r;
  endfunction

  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] px_r;
  logic [PIX_W-1:0] bl_r;
  cell_pos_t        pos_r;
  item_ctl_t        ctl_r;
  logic [PIX_W-1:0] prev_tr_r;
  logic [PIX_W-1:0] edge_px_r;
  logic [PIX_W-1:0] tr;
  logic [PIX_W-1:0] tl;
  logic             adv;

  // last column is held in a register, the store keeps the other columns
  assign tr  = ctl_r.last_col ? edge_px_r : rd_data;
  // top-left is the top-right read by the previous item of the row
  assign tl  = prev_tr_r;
  assign adv = s1_valid_r && (!ctl_r.emit || out_ready);

  assign ready        = !s1_valid_r || adv;
  assign cell_valid   = s1_valid_r && ctl_r.emit;
  assign cell_pos     = pos_r;
  assign right_color  = mean2(tl, tr);
  assign below_color  = mean2(tl, bl_r);
  assign center_color = mean4(tl, tr, bl_r, px_r);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ctl_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (load) begin
        ctl_r <= load_ctl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r  <= load_px;
      bl_r  <= load_bl;
      pos_r <= load_pos;
    end
    if (adv) begin
      prev_tr_r <= tr;
      if (ctl_r.last_col) begin
        edge_px_r <= px_r;
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid && !out_ready) |=> (s1_valid_r && $stable(px_r) && $stable(pos_r)))
    else $error("stalled cell lost its operands");

endmodule

// ----- rtl/core/bl2x_out.sv -----
module bl2x_out #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cell_valid,
  input  bl2x_pkg::cell_pos_t       cell_pos,
  input  logic [3*CHANNEL_BITS-1:0] right_color,
  input  logic [3*CHANNEL_BITS-1:0] below_color,
  input  logic [3*CHANNEL_BITS-1:0] center_color,
  output logic                      cell_ready,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [bl2x_pkg::XY_W-1:0] res_x,
  output logic [bl2x_pkg::XY_W-1:0] res_y,
  output logic [3*CHANNEL_BITS-1:0] res_color,
  output logic                      res_last
);
  import bl2x_pkg::*;

  localparam int PIX_W = 3 * CHANNEL_BITS;

  logic             busy_r, busy_nxt;
  logic [1:0]       beat_r, beat_nxt;
  cell_pos_t        pos_r;
  logic [PIX_W-1:0] right_r;
  logic [PIX_W-1:0] below_r;
  logic [PIX_W-1:0] center_r;
  logic             cell_load;
  logic             beat_done;

  assign beat_done  = busy_r && res_ready;
  assign cell_ready = !busy_r || (res_ready && beat_r == BEAT_CENTER);
  assign cell_load  = cell_valid && cell_ready;

  always_comb begin
    busy_nxt = busy_r;
    beat_nxt = beat_r;
    if (cell_load) begin
      busy_nxt = 1'b1;
      beat_nxt = BEAT_RIGHT;
    end else if (beat_done) begin
      if (beat_r == BEAT_CENTER) begin
        busy_nxt = 1'b0;
        beat_nxt = BEAT_RIGHT;
      end else begin
        beat_nxt = beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= BEAT_RIGHT;
    end else begin
      busy_r <= busy_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_load) begin
      pos_r    <= cell_pos;
      right_r  <= right_color;
      below_r  <= below_color;
      center_r <= center_color;
    end
  end

  // x and y of the corner are even, so +1 just sets bit 0
  always_comb begin
    res_x     = pos_r.x;
    res_y     = pos_r.y;
    res_color = right_r;
    res_last  = 1'b0;
    case (beat_r)
      BEAT_RIGHT: begin
        res_x[0] = 1'b1;
      end
      BEAT_BELOW: begin
        res_y[0]  = 1'b1;
        res_color = below_r;
      end
      BEAT_CENTER: begin
        res_x[0]  = 1'b1;
        res_y[0]  = 1'b1;
        res_color = center_r;
        res_last  = 1'b1;
      end
      default: begin
        res_color = right_r;
      end
    endcase
  end

  assign res_valid = busy_r;

  a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !res_ready) |=> (busy_r && $stable(beat_r)))
    else $error("beat index moved while receiver stalled");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cell_load |-> (!busy_r || (res_ready && beat_r == BEAT_CENTER)))
    else $error("cell loaded over an unfinished cell");

endmodule

// ----- rtl/core/bilinear_2x_upscale.sv -----
// Bilinear 2x upscaler, half-resolution RGB in, filled full-resolution pixels out.
// Input stream: one low-res pixel per beat in raster order, in_tdata = color.
// Output stream: three beats per 2x2 cell closed by an input pixel (row and
// column >= 1): right neighbor, lower neighbor, then center with out_tuser = 1.
// Pixels in row 0 or column 0 close no cell and produce nothing.
// Config: cfg_we with cfg_addr 0 (low_width) or 1 (low_height), values
// saturated to 2..MAX_LOW_WIDTH and 2..1024; a write to either restarts the frame.
// A cell's input beat is registered in the interpolation stage, then in the result
// stage, whose single port sends the three beats in turn; non-emitting pixels pass
// at one per cycle unless a stalled cell waits in the interpolation stage. The
// previous row lives in a MAX_LOW_WIDTH-entry RAM, read per accepted pixel and
// written for each one outside column 0. Reset restores the default geometry and
// restarts at row 0, column 0; the line RAM is not cleared (entries are written
// before the next row reads them). A stalled out_tready holds the current beat;
// one cell waits in the interpolation stage, after which in_tready drops.
module bilinear_2x_upscale #(
  parameter int MAX_LOW_WIDTH = 1024,
  parameter int CHANNEL_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // pixel_color
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_x, out_y, out_color
  output logic [((2*bl2x_pkg::XY_W+3*CHANNEL_BITS+7)/8)*8-1:0] out_tdata,
  // cell_last
  output logic                                  out_tuser,
  input  logic                                  cfg_we,
  input  logic [bl2x_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [bl2x_pkg::CFG_W-1:0]            cfg_wdata
);
  import bl2x_pkg::*;

  localparam int PIX_W      = 3 * CHANNEL_BITS;
  localparam int CW         = $clog2(MAX_LOW_WIDTH);
  localparam int OUT_TD_W   = ((2 * XY_W + PIX_W + 7) / 8) * 8;
  localparam int RST_W      = (RESET_LOW_WIDTH > MAX_LOW_WIDTH) ?
                              MAX_LOW_WIDTH : RESET_LOW_WIDTH;
  localparam int RST_WLAST  = RST_W - 1;
  localparam int RST_HLAST  = RESET_LOW_HEIGHT - 1;

  logic [CW-1:0]    wlast_r, wlast_nxt;
  logic [ROW_W-1:0] hlast_r, hlast_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] left_r;
  logic             cfg_hit;
  logic             accept;
  logic             s1_ready;
  logic [PIX_W-1:0] pixel;

  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [CW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_data;

  logic [CW-1:0]    col_m1;
  logic [ROW_W-1:0] row_m1;
  cell_pos_t        ld_pos;
  item_ctl_t        ld_ctl;

  logic             cell_valid;
  logic             cell_ready;
  cell_pos_t        cell_pos;
  logic [PIX_W-1:0] right_color;
  logic [PIX_W-1:0] below_color;
  logic [PIX_W-1:0] center_color;
  logic [XY_W-1:0]  res_x;
  logic [XY_W-1:0]  res_y;
  logic [PIX_W-1:0] res_color;

  assign pixel     = in_tdata[PIX_W-1:0];
  assign in_tready = s1_ready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_hit   = cfg_we && (cfg_addr == REG_LOW_WIDTH || cfg_addr == REG_LOW_HEIGHT);

  // geometry, kept as last index after saturation
  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_we && cfg_addr == REG_LOW_WIDTH) begin
      if (cfg_wdata < CFG_W'(2)) begin
        wlast_nxt = CW'(1);
      end else if (32'(cfg_wdata) > 32'(MAX_LOW_WIDTH)) begin
        wlast_nxt = CW'(MAX_LOW_WIDTH - 1);
      end else begin
        wlast_nxt = CW'(cfg_wdata - CFG_W'(1));
      end
    end
    if (cfg_we && cfg_addr == REG_LOW_HEIGHT) begin
      if (cfg_wdata < CFG_W'(2)) begin
        hlast_nxt = ROW_W'(1);
      end else if (32'(cfg_wdata) > 32'(ROW_LIMIT)) begin
        hlast_nxt = ROW_W'(ROW_LIMIT - 1);
      end else begin
        hlast_nxt = ROW_W'(cfg_wdata - CFG_W'(1));
      end
    end
  end

  // raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == wlast_r) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= CW'(RST_WLAST);
      hlast_r <= ROW_W'(RST_HLAST);
      col_r   <= '0;
      row_r   <= '0;
      left_r  <= '0;
    end else begin
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (accept) begin
        left_r <= pixel;
      end
    end
  end

  // line RAM: read this column's upper pixel, retire the left pixel one column back
  assign rd_addr = col_r;
  assign wr_en   = accept && (col_r != '0);
  assign wr_addr = col_r - CW'(1);

  assign col_m1 = col_r - CW'(1);
  assign row_m1 = row_r - ROW_W'(1);
  assign ld_pos.x = XY_W'({col_m1, 1'b0});
  assign ld_pos.y = {row_m1, 1'b0};
  assign ld_ctl.emit     = (col_r != '0) && (row_r != '0);
  assign ld_ctl.last_col = (col_r == wlast_r);

  bl2x_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LOW_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (left_r),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bl2x_interp #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_interp (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .load_px      (pixel),
    .load_bl      (left_r),
    .load_pos     (ld_pos),
    .load_ctl     (ld_ctl),
    .ready        (s1_ready),
    .rd_data      (rd_data),
    .out_ready    (cell_ready),
    .cell_valid   (cell_valid),
    .cell_pos     (cell_pos),
    .right_color  (right_color),
    .below_color  (below_color),
    .center_color (center_color)
  );

  bl2x_out #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (cell_valid),
    .cell_pos     (cell_pos),
    .right_color  (right_color),
    .below_color  (below_color),
    .center_color (center_color),
    .cell_ready   (cell_ready),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_color    (res_color),
    .res_last     (out_tuser)
  );

  assign out_tdata = OUT_TD_W'({res_color, res_y, res_x});

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r)
    else $error("column counter beyond row width");

  a_ram_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr != rd_addr))
    else $error("line RAM read and write hit the same entry");

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bl2x_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int OUT_W       = ((2 * XY_W + PIX_W + 7) / 8) * 8;
  localparam int SETTLE      = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_ITEMS  = 440;
  localparam int MAX_REPORTS = 10;

  // no register behind this index; a write must leave the frame alone
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [PIX_W-1:0]   in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic               out_tuser;
  logic               cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;

  bilinear_2x_upscale #(
    .MAX_LOW_WIDTH(MAX_W),
    .CHANNEL_BITS (CH_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  typedef struct {
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [PIX_W-1:0] color;
    logic             last;
  } fill_px_t;

  typedef enum logic {DIR_PIXEL, DIR_WRITE} dir_kind_t;

  typedef struct packed {
    dir_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0]      value;
    logic [PIX_W-1:0]      color;
    logic                  typed;
    logic [PIX_W-1:0]      want_right;
    logic [PIX_W-1:0]      want_below;
    logic [PIX_W-1:0]      want_center;
  } dir_row_t;

  // expected filled pixels, oldest first
  fill_px_t fill_q[$];

  // upscaler state as predicted
  logic [PIX_W-1:0] row_mem [MAX_W];
  logic [PIX_W-1:0] left_px;
  int unsigned      col_n;
  int unsigned      row_n;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  int  mismatches;
  bit  in_burst;
  bit  rx_fast;

  dir_row_t dir_tab[$];

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    logic [CH_W:0]    s;
    for (int k = 0; k < 3; k++) begin
      s = {1'b0, a[k*CH_W +: CH_W]} + {1'b0, b[k*CH_W +: CH_W]};
      r[k*CH_W +: CH_W] = s[CH_W:1];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c,
                                            input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] r;
    logic [CH_W+1:0]  s;
    for (int k = 0; k < 3; k++) begin
      s = {2'b00, a[k*CH_W +: CH_W]} + {2'b00, b[k*CH_W +: CH_W]}
        + {2'b00, c[k*CH_W +: CH_W]} + {2'b00, d[k*CH_W +: CH_W]};
      r[k*CH_W +: CH_W] = s[CH_W+1:2];
    end
    return r;
  endfunction

  function automatic dir_row_t pix(input logic [PIX_W-1:0] color);
    dir_row_t row;
    row = '0;
    row.kind = DIR_PIXEL;
    row.color = color;
    return row;
  endfunction

  // pixel that closes a cell whose three colors are known by hand
  function automatic dir_row_t closing(input logic [PIX_W-1:0] color,
                                       input logic [PIX_W-1:0] right,
                                       input logic [PIX_W-1:0] below,
                                       input logic [PIX_W-1:0] center);
    dir_row_t row;
    row = pix(color);
    row.typed = 1'b1;
    row.want_right = right;
    row.want_below = below;
    row.want_center = center;
    return row;
  endfunction

  function automatic dir_row_t wr(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_W-1:0] value);
    dir_row_t row;
    row = '0;
    row.kind = DIR_WRITE;
    row.addr = addr;
    row.value = value;
    return row;
  endfunction

  function automatic int pick_dim(input int hi);
    case ($urandom_range(0, 11))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(MAX_W + 1, 2047);
      2:       return $urandom_range(hi + 1, 4 * hi);
      default: return $urandom_range(2, hi);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_color();
    logic [PIX_W-1:0] p;
    p = PIX_W'($urandom);
    // corner channel values now and then, to hit carries and truncation
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0:       p[k*CH_W +: CH_W] = 8'h00;
          1:       p[k*CH_W +: CH_W] = 8'h01;
          2:       p[k*CH_W +: CH_W] = 8'h7F;
          3:       p[k*CH_W +: CH_W] = 8'h80;
          4:       p[k*CH_W +: CH_W] = 8'hFE;
          default: p[k*CH_W +: CH_W] = 8'hFF;
        endcase
      end
    end
    return p;
  endfunction

  task automatic add_fill(input int unsigned x, input int unsigned y,
                          input logic [PIX_W-1:0] color, input logic last);
    fill_px_t f;
    f.x = x[XY_W-1:0];
    f.y = y[XY_W-1:0];
    f.color = color;
    f.last = last;
    fill_q.push_back(f);
  endtask

  task automatic upscale_pixel(input logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    w = clamp_dim(32'(width_reg), MAX_W);
    h = clamp_dim(32'(height_reg), ROW_LIMIT);
    c = (col_n >= w) ? w - 1 : col_n;
    r = (row_n >= h) ? h - 1 : row_n;
    if (c >= 1) begin
      if (r >= 1) begin
        tl = row_mem[c-1];
        tr = row_mem[c];
        add_fill(2 * (c - 1) + 1, 2 * (r - 1), avg2(tl, tr), 1'b0);
        add_fill(2 * (c - 1), 2 * (r - 1) + 1, avg2(tl, left_px), 1'b0);
        add_fill(2 * (c - 1) + 1, 2 * (r - 1) + 1, avg4(tl, tr, left_px, px), 1'b1);
      end
      row_mem[c-1] = left_px;
    end
    if (c == w - 1) row_mem[c] = px;
    left_px = px;
    if (c + 1 >= w) begin
      col_n = 0;
      row_n = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_n = c + 1;
      row_n = r;
    end
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] color);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= color;
    do @(posedge clk); while (!in_tready);
    upscale_pixel(color);
  endtask

  // stop sending, let every expected beat drain, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (fill_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (addr == REG_LOW_WIDTH || addr == REG_LOW_HEIGHT) begin
      if (addr == REG_LOW_WIDTH) width_reg = value;
      else height_reg = value;
      col_n = 0;
      row_n = 0;
    end
  endtask

  // result side: random stalls, with fast stretches
  initial begin : rx
    int stall;
    int beats;
    out_tready = 1'b0;
    rx_fast = 1'b0;
    beats = 0;
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      beats++;
      if (beats % 32 == 0) rx_fast = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin : check_out
    fill_px_t         want;
    logic [XY_W-1:0]  gx;
    logic [XY_W-1:0]  gy;
    logic [PIX_W-1:0] gc;
    if (rst_n && out_tvalid && out_tready) begin
      gx = out_tdata[XY_W-1:0];
      gy = out_tdata[2*XY_W-1:XY_W];
      gc = out_tdata[2*XY_W+PIX_W-1:2*XY_W];
      if (fill_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: x=%0d y=%0d color=%06h last=%0b", gx, gy, gc, out_tuser);
      end else begin
        want = fill_q.pop_front();
        if (gx !== want.x || gy !== want.y || gc !== want.color || out_tuser !== want.last)
        begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: got %0d,%0d %06h %0b, want %0d,%0d %06h %0b",
                     gx, gy, gc, out_tuser, want.x, want.y, want.color, want.last);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("bilinear_2x_upscale regression: fail");
    $finish;
  end

  initial begin : stim
    int w_cfg;
    int h_cfg;
    int w_eff;
    int h_eff;
    int n;
    int sel;
    int rand_items;
    int hi;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_LOW_WIDTH;
    cfg_wdata  = '0;
    mismatches = 0;
    in_burst   = 1'b0;
    left_px    = '0;
    col_n      = 0;
    row_n      = 0;
    width_reg  = RESET_LOW_WIDTH;
    height_reg = RESET_LOW_HEIGHT;
    rand_items = 0;

    dir_tab = '{
      pix(24'hFFFFFF),                         // default geometry, row 0: nothing out
      wr(REG_LOW_WIDTH, 11'd0),                // saturates to 2
      wr(REG_LOW_HEIGHT, 11'd0),               // saturates to 2
      pix(24'hFFFFFF), pix(24'hFFFFFF), pix(24'hFFFFFF),
      closing(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF),
      pix(24'h000000), pix(24'h000000), pix(24'h000000),   // frame wrapped
      closing(24'h000000, 24'h000000, 24'h000000, 24'h000000),
      pix(24'hFF00FF), pix(24'h00FF00), pix(24'hFFFFFF),
      closing(24'h010203, 24'h7F7F7F, 24'hFF7FFF, 24'h7F8080),
      pix(24'h123456),
      wr(REG_SPARE, 11'h7FF),                  // mid-frame, must not restart
      pix(24'h654321), pix(24'hABCDEF), pix(24'hFEDCBA),
      wr(REG_LOW_WIDTH, 11'd1),
      wr(REG_LOW_HEIGHT, 11'd1),
      pix(24'h55AA55), pix(24'hAA55AA), pix(24'h0F0F0F), pix(24'hF0F0F0),
      wr(REG_LOW_WIDTH, 11'd2047),             // saturates to full line
      wr(REG_LOW_HEIGHT, 11'd2047),
      pix(24'h800000), pix(24'h008001)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == DIR_WRITE) begin
        drain();
        write_reg(dir_tab[i].addr, dir_tab[i].value);
      end else begin
        push_pixel(dir_tab[i].color);
        if (dir_tab[i].typed && fill_q.size() >= 3) begin
          fill_q[fill_q.size()-3].color = dir_tab[i].want_right;
          fill_q[fill_q.size()-2].color = dir_tab[i].want_below;
          fill_q[fill_q.size()-1].color = dir_tab[i].want_center;
        end
      end
    end

    while (rand_items < RAND_ITEMS) begin
      drain();
      in_burst = ($urandom_range(0, 4) == 0);
      w_cfg = pick_dim(12);
      h_cfg = pick_dim(6);
      sel = $urandom_range(0, 5);
      case (sel)
        0: write_reg(REG_LOW_WIDTH, CFG_W'(w_cfg));
        1: write_reg(REG_LOW_HEIGHT, CFG_W'(h_cfg));
        2: begin
          write_reg(REG_SPARE, CFG_W'($urandom_range(0, 2047)));
          write_reg(REG_LOW_HEIGHT, CFG_W'(h_cfg));
          write_reg(REG_LOW_WIDTH, CFG_W'(w_cfg));
        end
        default: begin
          write_reg(REG_LOW_WIDTH, CFG_W'(w_cfg));
          write_reg(REG_LOW_HEIGHT, CFG_W'(h_cfg));
        end
      endcase
      w_eff = clamp_dim(32'(width_reg), MAX_W);
      h_eff = clamp_dim(32'(height_reg), ROW_LIMIT);
      // mostly whole frames or more, so the wrap gets exercised
      hi = w_eff * ((h_eff < 4) ? h_eff : 4) * 2 + 3;
      n = $urandom_range(2 * w_eff, hi);
      if (n > 120) n = $urandom_range(40, 120);
      repeat (n) push_pixel(rand_color());
      rand_items += n;
    end

    drain();
    repeat (16) @(posedge clk);
    if (fill_q.size() != 0)
      $display("%0d expected beats never arrived", fill_q.size());
    if (mismatches == 0 && fill_q.size() == 0)
      $display("bilinear_2x_upscale regression: pass");
    else
      $display("bilinear_2x_upscale regression: fail");
    $finish;
  end

endmodule
